// ===== rtl/core/ptrt_pkg.sv =====
// Shared types and codes for the point in triangle region test block.
package ptrt_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_QUERY  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_SEPARATE = 2'd0,
        MODE_FAN      = 2'd1,
        MODE_STRIP    = 2'd2
    } t_mode;

    localparam logic [1:0] MODE_RESET = 2'd1;
    // mode code 3: queries skip the walk, the store forms no triangles
    localparam logic [1:0] MODE_NONE  = 2'd3;

    typedef struct packed {
        logic signed [15:0] y;
        logic signed [15:0] x;
    } t_vtx;

    typedef struct packed {
        logic busy;
        logic hit_valid;
        logic hit;
    } t_pipe_stat;

endpackage

// ===== rtl/core/ptrt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module ptrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/ptrt_tri_pipe.sv =====
// Four-stage pipeline testing one triangle per cycle for strict containment of a point.
module ptrt_tri_pipe (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  ptrt_pkg::t_vtx       i_p0,
    input  ptrt_pkg::t_vtx       i_p1,
    input  ptrt_pkg::t_vtx       i_p2,
    input  ptrt_pkg::t_vtx       i_q,
    output ptrt_pkg::t_pipe_stat o_stat
);

    function automatic logic signed [16:0] sub17(logic signed [15:0] a, logic signed [15:0] b);
        sub17 = 17'({a[15], a}) - 17'({b[15], b});
    endfunction

    logic r_s1_valid, r_s2_valid, r_s3_valid, r_hit_valid, r_hit;

    logic signed [16:0] r_v1x, r_v1y, r_v2x, r_v2y, r_wx, r_wy;
    logic signed [33:0] r_m_d0, r_m_d1, r_m_a0, r_m_a1, r_m_b0, r_m_b1;
    logic signed [34:0] r_d, r_na, r_nb;

    logic signed [35:0] sum_ab, d_ext;
    logic               hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_hit_valid <= 1'b0;
        end else begin
            r_s1_valid  <= i_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_hit_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v1x <= sub17(i_p1.x, i_p0.x);
        r_v1y <= sub17(i_p1.y, i_p0.y);
        r_v2x <= sub17(i_p2.x, i_p0.x);
        r_v2y <= sub17(i_p2.y, i_p0.y);
        r_wx  <= sub17(i_q.x, i_p0.x);
        r_wy  <= sub17(i_q.y, i_p0.y);

        r_m_d0 <= r_v1x * r_v2y;
        r_m_d1 <= r_v1y * r_v2x;
        r_m_a0 <= r_wx * r_v2y;
        r_m_a1 <= r_wy * r_v2x;
        r_m_b0 <= r_v1x * r_wy;
        r_m_b1 <= r_v1y * r_wx;

        r_d  <= 35'(r_m_d0) - 35'(r_m_d1);
        r_na <= 35'(r_m_a0) - 35'(r_m_a1);
        r_nb <= 35'(r_m_b0) - 35'(r_m_b1);

        r_hit <= hit;
    end

    always_comb begin
        sum_ab = 36'(r_na) + 36'(r_nb);
        d_ext  = 36'(r_d);
        if (r_d > 35'sd0) begin
            hit = (r_na > 35'sd0) && (r_nb > 35'sd0) && (sum_ab < d_ext);
        end else if (r_d < 35'sd0) begin
            hit = (r_na < 35'sd0) && (r_nb < 35'sd0) && (sum_ab > d_ext);
        end else begin
            hit = 1'b0;
        end
    end

    assign o_stat.busy      = r_s1_valid | r_s2_valid | r_s3_valid | r_hit_valid;
    assign o_stat.hit_valid = r_hit_valid;
    assign o_stat.hit       = r_hit;

endmodule

// ===== rtl/core/point_in_triangle_region_test_top.sv =====
// Top level of the point in triangle region test: vertex store, query sequencer, result beat.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: point_x, point_y; tuser: command
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: inside_res, store_full, vertex_count
//  cfg       in   i_cfg_we                      i_cfg_wdata: primitive_mode
//
//  Clear and insert need no walk. During a query the vertex RAM read port
//  delivers one vertex per cycle, then the triangle pipeline drains. Mode 3
//  queries skip the walk. Reset is synchronous and returns the count to zero and
//  the mode to fan; RAM contents are not cleared. A stalled result beat holds
//  the block before the next input beat is taken.
module point_in_triangle_region_test_top #(
    parameter int MAX_VERTICES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // point_x[15:0], point_y[31:16]
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // inside_res[0], store_full[1], vertex_count[10:2], zero
);

    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int AW = $clog2(MAX_VERTICES);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_READ  = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [1:0]           r_mode;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_limit;
    logic [CW-1:0]        r_rd_idx;
    logic [1:0]           r_mod3;
    ptrt_pkg::t_vtx       r_q;
    logic                 r_p1_valid, r_p1_first, r_p1_tri;
    ptrt_pkg::t_vtx       r_anchor, r_wa, r_wb;
    logic                 r_acc;
    logic                 r_out_valid, r_out_inside, r_out_full;
    logic [8:0]           r_out_count;

    logic                 in_acc, out_free, rd_en, full, wr_en, drain_done, tri_flag;
    logic [31:0]          rdata;
    ptrt_pkg::t_vtx       rd_vtx, p0;
    ptrt_pkg::t_pipe_stat stat;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign full          = (r_count == CW'(MAX_VERTICES));
    assign wr_en         = in_acc && (s_axis_tuser == ptrt_pkg::CMD_INSERT) && !full;
    assign rd_en         = (r_state == S_READ) && (r_rd_idx != r_limit);
    assign drain_done    = !r_p1_valid && !stat.busy;

    always_comb begin
        if (r_mode == ptrt_pkg::MODE_SEPARATE) begin
            tri_flag = (r_mod3 == 2'd2);
        end else begin
            tri_flag = (r_rd_idx > CW'(1));
        end
    end

    always_comb begin
        n_count = r_count;
        if (in_acc) begin
            unique case (ptrt_pkg::t_cmd'(s_axis_tuser))
                ptrt_pkg::CMD_CLEAR:  n_count = '0;
                ptrt_pkg::CMD_INSERT: n_count = full ? r_count : r_count + CW'(1);
                default:              n_count = r_count;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (s_axis_tuser == ptrt_pkg::CMD_QUERY)) n_state = S_READ;
            end
            S_READ: begin
                if (!rd_en) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (drain_done && out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= ptrt_pkg::MODE_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_p1_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_p1_valid <= rd_en;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if ((in_acc && (s_axis_tuser != ptrt_pkg::CMD_QUERY)) ||
                ((r_state == S_DRAIN) && drain_done && out_free)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_q      <= ptrt_pkg::t_vtx'(s_axis_tdata);
            r_limit  <= (r_mode == ptrt_pkg::MODE_NONE) ? '0 : r_count;
            r_rd_idx <= '0;
            r_mod3   <= 2'd0;
            r_acc    <= 1'b0;
        end else begin
            if (rd_en) begin
                r_rd_idx <= r_rd_idx + CW'(1);
                r_mod3   <= (r_mod3 == 2'd2) ? 2'd0 : r_mod3 + 2'd1;
            end
            if (stat.hit_valid && stat.hit) begin
                r_acc <= 1'b1;
            end
        end
        r_p1_first <= (r_rd_idx == '0);
        r_p1_tri   <= tri_flag;
        if (r_p1_valid) begin
            r_wa <= r_wb;
            r_wb <= rd_vtx;
            if (r_p1_first) begin
                r_anchor <= rd_vtx;
            end
        end
        if (in_acc && (s_axis_tuser != ptrt_pkg::CMD_QUERY)) begin
            r_out_inside <= 1'b0;
            r_out_full   <= (s_axis_tuser == ptrt_pkg::CMD_INSERT) && full;
            r_out_count  <= 9'(n_count);
        end else if ((r_state == S_DRAIN) && drain_done && out_free) begin
            r_out_inside <= r_acc;
            r_out_full   <= 1'b0;
            r_out_count  <= 9'(r_count);
        end
    end

    ptrt_ram #(
        .WIDTH (32),
        .DEPTH (MAX_VERTICES)
    ) u_vertex_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_re    (rd_en),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (rdata)
    );

    assign rd_vtx = ptrt_pkg::t_vtx'(rdata);
    assign p0     = (r_mode == ptrt_pkg::MODE_FAN) ? r_anchor : r_wa;

    ptrt_tri_pipe u_tri_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p1_valid && r_p1_tri),
        .i_p0    (p0),
        .i_p1    (r_wb),
        .i_p2    (rd_vtx),
        .i_q     (r_q),
        .o_stat  (stat)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_count, r_out_full, r_out_inside};

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_VERTICES))
        else $error("vertex count beyond store depth");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (r_rd_idx < r_count))
        else $error("vertex read beyond stored count");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (s_axis_tuser == ptrt_pkg::CMD_CLEAR)) |=> (r_count == '0))
        else $error("clear did not empty the store");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_inside && r_out_full))
        else $error("inside and full flags both set");

    a_no_pipe_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_p1_valid && !stat.busy))
        else $error("triangle pipeline active while idle");
`endif

endmodule
